// ----- hw/rtl/dde_pkg.sv -----
// Shared types, constants and the month table for the date-to-epoch converter.
package dde_pkg;

  localparam int CH_W      = 8;
  localparam int SEC_W     = 34;
  localparam int ZONE_W    = 18;
  localparam int YEAR_W    = 8;
  localparam int DAYS_W    = 17;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_OFFSET  = 1'd1;

  // Reset value of the default year and the first year counted (1970 - 1900).
  localparam logic [YEAR_W-1:0] DEF_YEAR_RST = 8'd70;
  localparam logic [YEAR_W-1:0] EPOCH_YY     = 8'd70;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_YEARS,
    S_MUL1,
    S_MUL2,
    S_LOAD
  } dde_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic parse;
    logic init;
    logic year_step;
    logic mul1;
    logic mul2;
    logic load_out;
  } dde_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic years_done;
    logic out_free;
  } dde_sts_t;

  // Days in the months before the given month of a non-leap year.
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    d = 9'd0;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/dde_ctrl.sv -----
// Controller state machine: sequences character parsing, the year count and the multiplies.
module dde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  dde_pkg::dde_sts_t   sts,
  output dde_pkg::dde_ctl_t   ctl
);

  dde_pkg::dde_state_t state_r;
  dde_pkg::dde_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dde_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dde_pkg::S_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = dde_pkg::S_INIT;
        end
      end
      dde_pkg::S_INIT: begin
        state_nxt = dde_pkg::S_YEARS;
      end
      dde_pkg::S_YEARS: begin
        if (sts.years_done) begin
          state_nxt = dde_pkg::S_MUL1;
        end
      end
      dde_pkg::S_MUL1: begin
        state_nxt = dde_pkg::S_MUL2;
      end
      dde_pkg::S_MUL2: begin
        state_nxt = dde_pkg::S_LOAD;
      end
      dde_pkg::S_LOAD: begin
        if (sts.out_free) begin
          state_nxt = dde_pkg::S_IDLE;
        end
      end
      default: state_nxt = dde_pkg::S_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dde_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctl.parse = in_valid;
      end
      dde_pkg::S_INIT: begin
        ctl.init = 1'b1;
      end
      dde_pkg::S_YEARS: begin
        ctl.year_step = !sts.years_done;
      end
      dde_pkg::S_MUL1: begin
        ctl.mul1 = 1'b1;
      end
      dde_pkg::S_MUL2: begin
        ctl.mul2 = 1'b1;
      end
      dde_pkg::S_LOAD: begin
        ctl.load_out = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dde_dpath.sv -----
// Datapath: character parser, range checks, year accumulator, time multiplies and result register.
module dde_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dde_pkg::CH_W-1:0]          in_ch,
  input  logic                              cfg_we,
  input  logic [dde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dde_pkg::ZONE_W-1:0]        cfg_data,
  input  dde_pkg::dde_ctl_t                 ctl,
  output dde_pkg::dde_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [dde_pkg::SEC_W-1:0]  out_seconds,
  output logic                              out_bad
);

  localparam int DAYS_W = dde_pkg::DAYS_W;

  // Configuration registers.
  logic [dde_pkg::YEAR_W-1:0] def_year_r;
  logic [dde_pkg::ZONE_W-1:0] zone_r;

  // Parse state.
  logic [3:0] count_r;
  logic [3:0] high_r;
  logic [6:0] mon_r;
  logic [6:0] day_r;
  logic [6:0] hour_r;
  logic [6:0] min_r;
  logic [6:0] year_r;
  logic       nondig_r;

  // Calculation state.
  logic                         bad_r;
  logic [4:0]                   hr_r;
  logic [5:0]                   mn_r;
  logic [dde_pkg::YEAR_W-1:0]   yy_r;
  logic [dde_pkg::YEAR_W-1:0]   yc_r;
  logic [dde_pkg::DAYS_W-1:0]   days_r;
  logic [21:0]                  dh_r;
  logic [27:0]                  dhm_r;

  // Result register.
  logic                         out_valid_r;
  logic [dde_pkg::SEC_W-1:0]    out_sec_r;
  logic                         out_bad_r;

  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] pair;

  logic                       bad_nxt;
  logic                       h24;
  logic [dde_pkg::YEAR_W-1:0] yy_nxt;
  logic                       leap_adj;
  logic [dde_pkg::DAYS_W-1:0] days_nxt;
  logic [dde_pkg::SEC_W-1:0]  sec_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_year_r <= dde_pkg::DEF_YEAR_RST;
      zone_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dde_pkg::CFG_DEFAULT_YEAR: def_year_r <= cfg_data[dde_pkg::YEAR_W-1:0];
        dde_pkg::CFG_ZONE_OFFSET:  zone_r     <= cfg_data;
      endcase
    end
  end

  // Digit decode and pair value.
  assign is_digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
  assign digit    = is_digit ? in_ch[3:0] : 4'd0;
  assign pair     = 7'({3'd0, high_r} * 7'd10) + {3'd0, digit};

  // Character parser; cleared when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.load_out) begin
      count_r  <= '0;
      high_r   <= '0;
      mon_r    <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      min_r    <= '0;
      year_r   <= '0;
      nondig_r <= 1'b0;
    end else if (ctl.parse) begin
      if (!is_digit) begin
        nondig_r <= 1'b1;
      end
      if (count_r < 4'd10) begin
        if (!count_r[0]) begin
          high_r <= digit;
        end else begin
          unique case (count_r[3:1])
            3'd0:    mon_r  <= pair;
            3'd1:    day_r  <= pair;
            3'd2:    hour_r <= pair;
            3'd3:    min_r  <= pair;
            default: year_r <= pair;
          endcase
        end
      end
      if (count_r != 4'd15) begin
        count_r <= count_r + 4'd1;
      end
    end
  end

  // Range checks and the day count within the year.
  always_comb begin
    bad_nxt = nondig_r || (count_r < 4'd8) || (mon_r == 7'd0) || (mon_r > 7'd12) ||
              (day_r == 7'd0) || (day_r > 7'd31) || (min_r > 7'd59) || (hour_r > 7'd24);
    h24      = (hour_r == 7'd24);
    yy_nxt   = (count_r >= 4'd10) ? {1'b0, year_r} : def_year_r;
    leap_adj = (yy_nxt[1:0] == 2'd0) && (mon_r >= 7'd3);
    days_nxt = DAYS_W'(dde_pkg::cum_days(mon_r[3:0])) + DAYS_W'(leap_adj) +
               DAYS_W'(day_r) + DAYS_W'(h24) - DAYS_W'(1);
  end

  // Whole years are counted one per cycle from 1970 up to the target year.
  assign sts.years_done = bad_r || (yc_r >= yy_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      bad_r  <= bad_nxt;
      hr_r   <= h24 ? 5'd0 : hour_r[4:0];
      mn_r   <= min_r[5:0];
      yy_r   <= yy_nxt;
      yc_r   <= dde_pkg::EPOCH_YY;
      days_r <= days_nxt;
    end else if (ctl.year_step) begin
      yc_r   <= yc_r + 8'd1;
      days_r <= days_r + ((yc_r[1:0] == 2'd0) ? DAYS_W'(366) : DAYS_W'(365));
    end
  end

  // Days to hours, then hours to minutes.
  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      dh_r <= ({5'd0, days_r} * 22'd24) + {17'd0, hr_r};
    end
    if (ctl.mul2) begin
      dhm_r <= ({6'd0, dh_r} * 28'd60) + {22'd0, mn_r};
    end
  end

  // Minutes to seconds plus the zone offset, wrapped to the output width.
  assign sec_nxt = ({6'd0, dhm_r} * 34'd60) +
                   {{(dde_pkg::SEC_W-dde_pkg::ZONE_W){zone_r[dde_pkg::ZONE_W-1]}}, zone_r};

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_sec_r <= bad_r ? '0 : sec_nxt;
      out_bad_r <= bad_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_seconds = out_sec_r;
  assign out_bad     = out_bad_r;

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> out_valid_r)
    else $error("result not presented after load");

  // A flagged result carries zero seconds.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_sec_r == '0))
    else $error("bad result with nonzero seconds");

  // The parser starts empty after a result is loaded.
  a_parse_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> (count_r == 4'd0) && !nondig_r)
    else $error("parse state not cleared");

  // The year counter never steps past the target year.
  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.year_step |-> (yc_r < yy_r) && !bad_r)
    else $error("year step beyond target");

endmodule

// ----- hw/rtl/date_digits_to_epoch_seconds.sv -----
// Top level: converts an mmddhhmm[yy] character stream to epoch seconds with an error flag.
// Characters are taken one per cycle while idle; a character without last gives no result.
// After the last character come an init step, the year count, two multiplies and the load;
// the year accumulator counts the whole years from 1970 to the target year, one per cycle.
// No character is taken until the result is loaded; it waits in an output register.
// Reset (synchronous, active low) clears parse state and sets default year 70, offset 0.
module date_digits_to_epoch_seconds (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dde_pkg::CH_W-1:0]            in_ch,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dde_pkg::SEC_W-1:0]    out_seconds,
  output logic                                out_bad,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dde_pkg::ZONE_W-1:0]          cfg_data
);

  dde_pkg::dde_ctl_t ctl;
  dde_pkg::dde_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  dde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dde_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_seconds (out_seconds),
    .out_bad     (out_bad)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the date-string to epoch-seconds converter.
module tb_top;

  localparam int CH_W      = dde_pkg::CH_W;
  localparam int SEC_W     = dde_pkg::SEC_W;
  localparam int ZONE_W    = dde_pkg::ZONE_W;
  localparam int YEAR_W    = dde_pkg::YEAR_W;
  localparam int CFG_IDX_W = dde_pkg::CFG_IDX_W;
  localparam int PAD_W     = ZONE_W - YEAR_W;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_END    = 1450;
  localparam int ITEM_TARGET   = 1650;
  localparam int MAX_REPORTS   = 10;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Which two-digit field a character pair fills.
  typedef enum logic [2:0] {
    SLOT_MONTH,
    SLOT_DAY,
    SLOT_HOUR,
    SLOT_MINUTE,
    SLOT_YEAR
  } slot_t;

  typedef struct packed {
    logic signed [SEC_W-1:0] secs;
    logic                    bad;
  } stamp_t;

  typedef logic [CH_W-1:0] text_t [$];

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CH_W-1:0]          in_ch;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [SEC_W-1:0]  out_seconds;
  logic                     out_bad;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [ZONE_W-1:0]        cfg_data;

  // Predictor copy of the configuration and of the parse state.
  logic [YEAR_W-1:0]        def_year;
  logic signed [ZONE_W-1:0] zone;
  logic [3:0]               pos_cnt;
  logic [3:0]               hi_dig;
  logic [6:0]               mon_f;
  logic [6:0]               day_f;
  logic [6:0]               hr_f;
  logic [6:0]               min_f;
  logic [6:0]               yr_f;
  logic                     junk_seen;

  stamp_t stamp_q [$];
  stamp_t head;

  bit gaps_on;
  bit stalls_on;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_total  = 0;
  int cycle_cnt   = 0;
  int fail_count  = 0;
  int chars_sent  = 0;
  int dates_sent  = 0;
  int results_seen = 0;
  int bad_seen    = 0;
  int cfg_writes  = 0;

  date_digits_to_epoch_seconds u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ch       (in_ch),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_seconds (out_seconds),
    .out_bad     (out_bad),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // The run is cut off if it takes far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
               stamp_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Prediction

  task automatic clear_parse();
    pos_cnt   = '0;
    hi_dig    = '0;
    mon_f     = '0;
    day_f     = '0;
    hr_f      = '0;
    min_f     = '0;
    yr_f      = '0;
    junk_seen = 1'b0;
  endtask

  // Converts the collected fields into epoch seconds, or flags the string as bad.
  function automatic stamp_t convert_date();
    stamp_t r;
    logic   bad;
    int     t, d, h, m, y, i;
    longint days, secs;
    bad = junk_seen || (pos_cnt < 4'd8);
    t = mon_f;
    d = day_f;
    h = hr_f;
    m = min_f;
    if (t < 1 || t > 12 || d < 1 || d > 31 || m > 59) bad = 1'b1;
    // Hour 24 rolls into the next day without checking the day again.
    if (h == 24) begin
      h = 0;
      d++;
    end
    if (h > 23) bad = 1'b1;
    secs = 0;
    if (!bad) begin
      y = 1900 + ((pos_cnt >= 4'd10) ? int'(yr_f) : int'(def_year));
      days = 0;
      for (i = 1970; i < y; i++) days += (i % 4 != 0) ? 365 : 366;
      if (y % 4 == 0 && t >= 3) days++;
      for (i = 1; i < t; i++) days += MONTH_LEN[i-1];
      days += d - 1;
      secs = ((days * 24 + h) * 60 + m) * 60 + longint'(zone);
    end
    r.secs = secs[SEC_W-1:0];
    r.bad  = bad;
    return r;
  endfunction

  // Updates the parse state for one accepted character and queues a result on the last one.
  task automatic take_char(input logic [CH_W-1:0] c, input logic l);
    logic [3:0] dg;
    logic [6:0] pair;
    dg = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dg = 4'(c - CH_ZERO);
    end else begin
      junk_seen = 1'b1;
    end
    if (pos_cnt < 4'd10) begin
      if (!pos_cnt[0]) begin
        hi_dig = dg;
      end else begin
        pair = 7'(int'(hi_dig) * 10 + int'(dg));
        case (pos_cnt[3:1])
          SLOT_MONTH:  mon_f = pair;
          SLOT_DAY:    day_f = pair;
          SLOT_HOUR:   hr_f  = pair;
          SLOT_MINUTE: min_f = pair;
          default:     yr_f  = pair;
        endcase
      end
    end
    if (pos_cnt < 4'd15) pos_cnt++;
    if (l) begin
      stamp_q.push_back(convert_date());
      clear_parse();
    end
  endtask

  // Stimulus helpers

  function automatic logic [CH_W-1:0] any_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic text_t digits2(input int v);
    text_t r;
    r.push_back(8'(CH_ZERO + v / 10));
    r.push_back(8'(CH_ZERO + v % 10));
    return r;
  endfunction

  function automatic text_t to_text(input string s);
    text_t r;
    for (int i = 0; i < s.len(); i++) r.push_back(s[i]);
    return r;
  endfunction

  // Mostly well-formed date strings with random content, plus noise and broken ones.
  function automatic text_t random_date();
    text_t s;
    int    shape, tail, cut, pos, hr;
    bit    wild;
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      repeat ($urandom_range(1, 16)) s.push_back(any_char());
      return s;
    end
    wild = ($urandom_range(0, 5) == 0);
    hr = ($urandom_range(0, 7) == 0) ? 24 : int'($urandom_range(0, 23));
    s = {digits2(wild ? $urandom_range(0, 99) : $urandom_range(1, 12)),
         digits2(wild ? $urandom_range(0, 99) : $urandom_range(1, 31)),
         digits2(wild ? $urandom_range(0, 99) : hr),
         digits2(wild ? $urandom_range(0, 99) : $urandom_range(0, 59))};
    tail = $urandom_range(0, 99);
    if (tail >= 15 && tail < 25) begin
      s.push_back(any_char());
    end else if (tail >= 25) begin
      s = {s, digits2($urandom_range(0, 99))};
      if (tail >= 88) repeat ($urandom_range(1, 6)) s.push_back(any_char());
    end
    if (shape < 22) begin
      // One character replaced by an arbitrary byte.
      pos = $urandom_range(0, s.size() - 1);
      s[pos] = 8'($urandom_range(0, 255));
    end else if (shape < 28) begin
      // Cut short before the minutes are complete.
      cut = $urandom_range(1, 7);
      while (s.size() > cut) void'(s.pop_back());
    end
    return s;
  endfunction

  function automatic logic [YEAR_W-1:0] random_year();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd69;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ZONE_W-1:0] random_zone();
    int v;
    if ($urandom_range(0, 9) < 3) return 18'($urandom_range(0, 262143));
    v = int'($urandom_range(0, 172800)) - 86400;
    return v[ZONE_W-1:0];
  endfunction

  // Offers one character and waits for the request to be accepted.
  task automatic send_char(input logic [CH_W-1:0] c, input logic l);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_char(c, l);
    chars_sent++;
  endtask

  task automatic send_text(input text_t s);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
    dates_sent++;
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; the year register ignores the upper data bits.
  task automatic set_config(input logic [YEAR_W-1:0] yr, input logic [ZONE_W-1:0] zn);
    logic [PAD_W-1:0] pad;
    pad = ($urandom_range(0, 1) != 0) ? '1 : PAD_W'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= dde_pkg::CFG_DEFAULT_YEAR;
    cfg_data  <= {pad, yr};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    def_year = yr;
    cfg_index <= dde_pkg::CFG_ZONE_OFFSET;
    cfg_data  <= zn;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    zone = zn;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // Tests

  // Reset defaults, the epoch itself, hour 24 at year end, a short string, extra characters.
  task automatic test_directed();
    send_text(to_text("0101000070"));
    send_text(to_text("12312459"));
    send_text(to_text("1301000"));
    send_text(to_text("0229120096x7"));
    stop_input();
  endtask

  // Register extremes, including offsets beyond one day and the earliest and latest years.
  task automatic test_config_extremes();
    logic [YEAR_W-1:0] yrs [5]  = '{8'd0, 8'd255, 8'd99, 8'd200, 8'd70};
    logic [ZONE_W-1:0] zns [5]  = '{-18'sd86400, 18'sd86400, 18'h1FFFF, 18'h20000, 18'd0};
    for (int k = 0; k < 5; k++) begin
      wait_drained();
      set_config(yrs[k], zns[k]);
      repeat (6) send_text(random_date());
      stop_input();
    end
  endtask

  // Random settings per phase, with idling switched on and off between phases.
  task automatic test_random_phases();
    while (chars_sent < RANDOM_END) begin
      wait_drained();
      set_config(random_year(), random_zone());
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(8, 20)) send_text(random_date());
      stop_input();
    end
  endtask

  // The receiver holds off for a long stretch while characters keep coming.
  task automatic test_backpressure();
    wait_drained();
    gaps_on = 1'b0;
    hold_asked++;
    repeat (5) send_text(random_date());
    stop_input();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_no_idle();
    wait_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (chars_sent < ITEM_TARGET) send_text(random_date());
    stop_input();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_taker
    int burst;
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_total += held;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_bad) bad_seen++;
      if (stamp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Cycle %0d: result with nothing predicted, seconds %0d bad %0b",
                   cycle_cnt, out_seconds, out_bad);
      end else begin
        head = stamp_q.pop_front();
        if (out_seconds !== head.secs || out_bad !== head.bad) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Cycle %0d: seconds expected %0d got %0d, bad expected %0b got %0b",
                     cycle_cnt, head.secs, out_seconds, head.bad, out_bad);
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_ch     = '0;
    in_last   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dde_pkg::CFG_DEFAULT_YEAR;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    def_year = dde_pkg::DEF_YEAR_RST;
    zone     = '0;
    clear_parse();

    test_directed();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    test_no_idle();
    wait_drained();

    $display("Sent %0d characters in %0d date strings; %0d results checked, %0d flagged bad.",
             chars_sent, dates_sent, results_seen, bad_seen);
    $display("Made %0d register writes; output held off for %0d cycles; %0d mismatches.",
             cfg_writes, hold_total, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
